// ----- src/heightfield_triangle_height_assert.svh -----
// Assertion macros shared by the heightfield triangle height RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef HEIGHTFIELD_TRIANGLE_HEIGHT_ASSERT_SVH
`define HEIGHTFIELD_TRIANGLE_HEIGHT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HTH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/hth_pkg.sv -----
// Package for the heightfield triangle height block: widths, constants,
// controller states and the command and status structs. No dependencies.
package hth_pkg;

    localparam int DATA_W    = 16;
    localparam int SPACING_W = 15;
    localparam int INDEX_W   = 5;
    localparam int DIV_W     = 36;
    localparam int DIVISOR_W = SPACING_W + 1;
    localparam int SAT_POS   = 32767;
    localparam int SAT_NEG   = 32768;

    localparam logic [SPACING_W-1:0]     SPACING_RESET = 15'd1280;
    localparam logic signed [DATA_W-1:0] HEIGHT_RESET  = 16'sd256;
    localparam logic signed [DATA_W-1:0] HEIGHT_MAX    = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] HEIGHT_MIN    = 16'sh8000;

    typedef enum logic [1:0] {DSEL_U, DSEL_W, DSEL_N} div_sel_t;
    typedef enum logic [1:0] {VTX_00, VTX_10, VTX_01, VTX_11} vtx_t;
    typedef enum logic [1:0] {OUT_ZERO, OUT_OOR, OUT_VAL} out_kind_t;
    typedef enum logic [1:0] {TERM_BASE, TERM_X, TERM_Z} term_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_WRITE, ST_SETUP, ST_OFFS, ST_CHKOFF,
        ST_DIVU, ST_WAITU, ST_DIVW, ST_WAITW,
        ST_RD00, ST_RD10, ST_RD01, ST_RD11,
        ST_MAC0, ST_MAC1, ST_MAC2, ST_MAC3,
        ST_NUM, ST_DIVN, ST_WAITN, ST_DONE
    } hth_state_t;

    typedef struct packed {
        logic      in_ready;
        logic      clear_wr;
        logic      item_wr;
        logic      hs_load;
        logic      uw_load;
        logic      div_start;
        div_sel_t  div_sel;
        logic      cap_x;
        logic      cap_z;
        logic      rd_en;
        vtx_t      rd_sel;
        logic      mul_en;
        term_t     mul_sel;
        logic      acc_init;
        logic      acc_add;
        logic      num_prep;
        logic      out_load;
        out_kind_t out_kind;
    } hth_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_op;
        logic spacing_zero;
        logic clear_last;
        logic uw_neg;
        logic div_done;
        logic quo_big;
        logic out_free;
    } hth_status_t;

endpackage

// ----- src/hth_if.sv -----
// Channel interfaces of the heightfield triangle height block: input items,
// result items and the spacing register write. No dependencies.
interface hth_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [4:0]         x_index;
    logic [4:0]         z_index;
    logic signed [15:0] height_value;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_z;

    modport source (output valid, op, x_index, z_index, height_value, pos_x, pos_z,
                    input ready);
    modport sink (input valid, op, x_index, z_index, height_value, pos_x, pos_z,
                  output ready);
endinterface

interface hth_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] height;
    logic               out_of_range;

    modport source (output valid, height, out_of_range, input ready);
    modport sink (input valid, height, out_of_range, output ready);
endinterface

interface hth_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] cell_spacing;

    modport source (output valid, cell_spacing, input ready);
    modport sink (input valid, cell_spacing, output ready);
endinterface

// ----- src/hth_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on hth_pkg and the assertion macro header.
`include "heightfield_triangle_height_assert.svh"

module hth_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [hth_pkg::DIV_W-1:0]      dividend,
    input  logic [hth_pkg::DIVISOR_W-1:0]  divisor,
    output logic [hth_pkg::DIV_W-1:0]      quotient,
    output logic [hth_pkg::DIVISOR_W-1:0]  remainder,
    output logic                           done
);
    import hth_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dsr_reg;
    logic [DIVISOR_W:0]   rem_sh;
    logic [DIVISOR_W:0]   diff;

    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign diff   = rem_sh - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ~diff[DIVISOR_W]};
            rem_reg <= diff[DIVISOR_W] ? rem_sh[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

    `HTH_ASSERT_IMP(a_div_no_restart, start, !busy_reg, "divider started while busy")
    `HTH_ASSERT_NXT(a_div_runs, start, busy_reg && !done_reg, "divider did not begin")

endmodule

// ----- src/hth_dp.sv -----
// Datapath of the heightfield triangle height block: height memory, cell
// search, plane evaluation and the output register. Uses hth_pkg and hth_div.
`include "heightfield_triangle_height_assert.svh"

module hth_dp #(
    parameter int GRID_CELLS = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    hth_in_if.sink               item_in,
    hth_out_if.source            result_out,
    hth_cfg_if.sink              cfg,
    input  hth_pkg::hth_cmd_t    cmd,
    output hth_pkg::hth_status_t st
);
    import hth_pkg::*;

    localparam int SIDE  = GRID_CELLS + 1;
    localparam int DEPTH = SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(GRID_CELLS);
    localparam int HALF  = GRID_CELLS / 2;
    localparam int HW    = $clog2(HALF + 1);
    localparam int HSW   = HW + SPACING_W;
    localparam int UW    = HSW + 2;
    localparam int PW    = DATA_W + 1 + SPACING_W + 1;

    logic [SPACING_W-1:0]     spacing_reg;
    logic [INDEX_W-1:0]       xi_reg;
    logic [INDEX_W-1:0]       zi_reg;
    logic signed [DATA_W-1:0] hv_reg;
    logic signed [DATA_W-1:0] px_reg;
    logic signed [DATA_W-1:0] pz_reg;
    logic [HSW-1:0]           hs_reg;
    logic signed [UW-1:0]     u_reg;
    logic signed [UW-1:0]     w_reg;
    logic [CW-1:0]            ci_reg;
    logic [CW-1:0]            cj_reg;
    logic [SPACING_W-1:0]     fx_reg;
    logic [SPACING_W-1:0]     fz_reg;
    logic [AW-1:0]            clear_cnt_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [DIV_W-1:0]  acc_reg;
    logic [DIV_W-1:0]         num_mag_reg;
    logic                     num_neg_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] height_reg;
    logic                     oor_reg;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] vtx_reg [4];

    logic                     accept;
    logic                     out_free;
    logic                     wr_ok;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;
    logic                     di;
    logic                     dj;
    logic [DIV_W-1:0]         dvd;
    logic [DIVISOR_W-1:0]     dsr;
    logic [DIV_W-1:0]         quo;
    logic [DIVISOR_W-1:0]     rem;
    logic                     div_done;
    logic                     lower;
    logic signed [DATA_W:0]   op_a;
    logic signed [SPACING_W:0] op_b;
    logic [DIV_W-1:0]         num;
    logic [DATA_W-1:0]        q_lo;
    logic signed [DATA_W-1:0] height_val;

    assign accept         = item_in.valid && item_in.ready;
    assign item_in.ready  = cmd.in_ready;
    assign cfg.ready      = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= SPACING_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            spacing_reg <= cfg.cell_spacing;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xi_reg <= item_in.x_index;
            zi_reg <= item_in.z_index;
            hv_reg <= item_in.height_value;
            px_reg <= item_in.pos_x;
            pz_reg <= item_in.pos_z;
        end
    end

    // Grid origin offset and the point shifted into grid coordinates.
    always_ff @(posedge clk)
    begin
        if (cmd.hs_load)
        begin
            hs_reg <= HSW'(HALF) * HSW'(spacing_reg);
        end
        if (cmd.uw_load)
        begin
            u_reg <= UW'(px_reg) + UW'(hs_reg);
            w_reg <= UW'(hs_reg) - UW'(pz_reg);
        end
    end

    always_comb
    begin
        case (cmd.div_sel)
            DSEL_U:
            begin
                dvd = DIV_W'(u_reg[UW-2:0]);
                dsr = {1'b0, spacing_reg};
            end
            DSEL_W:
            begin
                dvd = DIV_W'(w_reg[UW-2:0]);
                dsr = {1'b0, spacing_reg};
            end
            DSEL_N:
            begin
                dvd = num_mag_reg;
                dsr = {spacing_reg, 1'b0};
            end
            default:
            begin
                dvd = '0;
                dsr = {1'b0, spacing_reg};
            end
        endcase
    end

    hth_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dvd),
        .divisor   (dsr),
        .quotient  (quo),
        .remainder (rem),
        .done      (div_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.cap_x)
        begin
            ci_reg <= quo[CW-1:0];
            fx_reg <= rem[SPACING_W-1:0];
        end
        if (cmd.cap_z)
        begin
            cj_reg <= quo[CW-1:0];
            fz_reg <= rem[SPACING_W-1:0];
        end
    end

    // Height memory with its clearing sweep after reset.
    assign wr_ok   = (int'(xi_reg) <= GRID_CELLS) && (int'(zi_reg) <= GRID_CELLS);
    assign wr_addr = AW'(xi_reg) * AW'(SIDE) + AW'(zi_reg);
    assign di      = (cmd.rd_sel == VTX_10) || (cmd.rd_sel == VTX_11);
    assign dj      = (cmd.rd_sel == VTX_01) || (cmd.rd_sel == VTX_11);
    assign rd_addr = (AW'(ci_reg) + AW'(di)) * AW'(SIDE) + AW'(cj_reg) + AW'(dj);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            mem[clear_cnt_reg] <= HEIGHT_RESET;
        end
        else if (cmd.item_wr && wr_ok)
        begin
            mem[wr_addr] <= hv_reg;
        end
        if (cmd.rd_en)
        begin
            vtx_reg[cmd.rd_sel] <= mem[rd_addr];
        end
    end

    // Plane numerator, one product per cycle into the accumulator.
    assign lower = ({1'b0, fx_reg} + {1'b0, fz_reg}) >= {1'b0, spacing_reg};

    always_comb
    begin
        case (cmd.mul_sel)
            TERM_BASE:
            begin
                op_a = lower ? (DATA_W+1)'(vtx_reg[VTX_11]) : (DATA_W+1)'(vtx_reg[VTX_00]);
                op_b = {1'b0, spacing_reg};
            end
            TERM_X:
            begin
                op_a = lower ? (DATA_W+1)'(vtx_reg[VTX_01]) - (DATA_W+1)'(vtx_reg[VTX_11])
                             : (DATA_W+1)'(vtx_reg[VTX_10]) - (DATA_W+1)'(vtx_reg[VTX_00]);
                op_b = lower ? {1'b0, spacing_reg} - {1'b0, fx_reg} : {1'b0, fx_reg};
            end
            TERM_Z:
            begin
                op_a = lower ? (DATA_W+1)'(vtx_reg[VTX_10]) - (DATA_W+1)'(vtx_reg[VTX_11])
                             : (DATA_W+1)'(vtx_reg[VTX_01]) - (DATA_W+1)'(vtx_reg[VTX_00]);
                op_b = lower ? {1'b0, spacing_reg} - {1'b0, fz_reg} : {1'b0, fz_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Floor division of a negative numerator uses (~num + den) as magnitude.
    assign num = {acc_reg[DIV_W-2:0], 1'b0} + DIV_W'(spacing_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= op_a * op_b;
        end
        if (cmd.acc_init)
        begin
            acc_reg <= DIV_W'(prod_reg);
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + DIV_W'(prod_reg);
        end
        if (cmd.num_prep)
        begin
            num_neg_reg <= num[DIV_W-1];
            num_mag_reg <= num[DIV_W-1] ? ~num + DIV_W'({spacing_reg, 1'b0}) : num;
        end
    end

    // Saturation of the signed quotient.
    assign q_lo = quo[DATA_W-1:0];

    always_comb
    begin
        if (num_neg_reg)
        begin
            height_val = (quo > DIV_W'(SAT_NEG)) ? HEIGHT_MIN : ~q_lo + 1'b1;
        end
        else
        begin
            height_val = (quo > DIV_W'(SAT_POS)) ? HEIGHT_MAX : q_lo;
        end
    end

    assign out_free = !out_valid_reg || result_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_kind)
                OUT_OOR:
                begin
                    height_reg <= '0;
                    oor_reg    <= 1'b1;
                end
                OUT_VAL:
                begin
                    height_reg <= height_val;
                    oor_reg    <= 1'b0;
                end
                default:
                begin
                    height_reg <= '0;
                    oor_reg    <= 1'b0;
                end
            endcase
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.height       = height_reg;
    assign result_out.out_of_range = oor_reg;

    assign st.in_valid     = item_in.valid;
    assign st.in_op        = item_in.op;
    assign st.spacing_zero = (spacing_reg == '0);
    assign st.clear_last   = (int'(clear_cnt_reg) == DEPTH - 1);
    assign st.uw_neg       = u_reg[UW-1] || w_reg[UW-1];
    assign st.div_done     = div_done;
    assign st.quo_big      = (quo >= DIV_W'(GRID_CELLS));
    assign st.out_free     = out_free;

    `HTH_ASSERT_IMP(a_load_has_slot, cmd.out_load, out_free, "result loaded over a waiting result")
    `HTH_ASSERT_IMP(a_clear_blocks_input, cmd.clear_wr, !item_in.ready, "item taken while clearing")
    `HTH_ASSERT_IMP(a_read_in_grid, cmd.rd_en, int'(rd_addr) < DEPTH, "vertex read outside grid")

endmodule

// ----- src/hth_ctrl.sv -----
// Controller of the heightfield triangle height block: sequences the memory
// clear, writes and the query steps. Depends on hth_pkg.
module hth_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hth_pkg::hth_status_t st,
    output hth_pkg::hth_cmd_t    cmd
);
    import hth_pkg::*;

    hth_state_t state_reg;
    hth_state_t state_next;
    out_kind_t  kind_reg;
    out_kind_t  kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            kind_reg  <= OUT_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (st.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (st.in_valid)
                begin
                    if (!st.in_op)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (st.spacing_zero)
                    begin
                        state_next = ST_DONE;
                        kind_next  = OUT_OOR;
                    end
                    else
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
                kind_next  = OUT_ZERO;
            end
            ST_SETUP:  state_next = ST_OFFS;
            ST_OFFS:   state_next = ST_CHKOFF;
            ST_CHKOFF:
            begin
                if (st.uw_neg)
                begin
                    state_next = ST_DONE;
                    kind_next  = OUT_OOR;
                end
                else
                begin
                    state_next = ST_DIVU;
                end
            end
            ST_DIVU:   state_next = ST_WAITU;
            ST_WAITU:
            begin
                if (st.div_done)
                begin
                    if (st.quo_big)
                    begin
                        state_next = ST_DONE;
                        kind_next  = OUT_OOR;
                    end
                    else
                    begin
                        state_next = ST_DIVW;
                    end
                end
            end
            ST_DIVW:   state_next = ST_WAITW;
            ST_WAITW:
            begin
                if (st.div_done)
                begin
                    if (st.quo_big)
                    begin
                        state_next = ST_DONE;
                        kind_next  = OUT_OOR;
                    end
                    else
                    begin
                        state_next = ST_RD00;
                    end
                end
            end
            ST_RD00:   state_next = ST_RD10;
            ST_RD10:   state_next = ST_RD01;
            ST_RD01:   state_next = ST_RD11;
            ST_RD11:   state_next = ST_MAC0;
            ST_MAC0:   state_next = ST_MAC1;
            ST_MAC1:   state_next = ST_MAC2;
            ST_MAC2:   state_next = ST_MAC3;
            ST_MAC3:   state_next = ST_NUM;
            ST_NUM:    state_next = ST_DIVN;
            ST_DIVN:   state_next = ST_WAITN;
            ST_WAITN:
            begin
                if (st.div_done)
                begin
                    state_next = ST_DONE;
                    kind_next  = OUT_VAL;
                end
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_CLEAR:  cmd.clear_wr = 1'b1;
            ST_IDLE:   cmd.in_ready = 1'b1;
            ST_WRITE:  cmd.item_wr = 1'b1;
            ST_SETUP:  cmd.hs_load = 1'b1;
            ST_OFFS:   cmd.uw_load = 1'b1;
            ST_DIVU:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_U;
            end
            ST_WAITU:  cmd.cap_x = st.div_done;
            ST_DIVW:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_W;
            end
            ST_WAITW:  cmd.cap_z = st.div_done;
            ST_RD00:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = VTX_00;
            end
            ST_RD10:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = VTX_10;
            end
            ST_RD01:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = VTX_01;
            end
            ST_RD11:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = VTX_11;
            end
            ST_MAC0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = TERM_BASE;
            end
            ST_MAC1:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = TERM_X;
                cmd.acc_init = 1'b1;
            end
            ST_MAC2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = TERM_Z;
                cmd.acc_add = 1'b1;
            end
            ST_MAC3:   cmd.acc_add = 1'b1;
            ST_NUM:    cmd.num_prep = 1'b1;
            ST_DIVN:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_N;
            end
            ST_DONE:
            begin
                cmd.out_load = st.out_free;
                cmd.out_kind = kind_reg;
            end
            default:   cmd = '0;
        endcase
    end

endmodule

// ----- src/heightfield_triangle_height.sv -----
// Top level of the heightfield triangle height block.
// Depends on hth_pkg, the channel interfaces, hth_ctrl, hth_dp and hth_div.
//
// Usage:
//   item_in carries one item per valid/ready handshake. An item with op = 0
//   stores height_value at grid vertex (x_index, z_index); indexes above
//   GRID_CELLS are ignored. An item with op = 1 returns the height of the
//   grid triangle under the point (pos_x, pos_z), all values signed Q8.8.
//   result_out returns exactly one result per item, in order; a write returns
//   zero, a point off the grid returns zero with out_of_range set.
//   cfg writes the cell spacing; it is always ready, and the user must write it
//   only while the block is idle; the block itself does not enforce this.
// Sequencing:
//   A write is stored in the WRITE state and loaded into the output register in
//   DONE. A query makes three passes through the shared bit-serial divider
//   (two cell searches and the final rounding division); a point rejected
//   early finishes sooner. One item is worked on at a time.
// Reset and stalls:
//   After reset all (GRID_CELLS+1)^2 entries of the height memory (441 at the
//   default) are swept to 1.0, one entry a cycle, before the first item is
//   taken. A stalled result waits in the output register; the next item is
//   still accepted and computed, and is held back only until that slot frees.
module heightfield_triangle_height #(
    parameter int GRID_CELLS = 20
) (
    input  logic      clk,
    input  logic      rst_n,
    hth_in_if.sink    item_in,
    hth_out_if.source result_out,
    hth_cfg_if.sink   cfg
);
    import hth_pkg::*;

    // Commands from the controller and status back from the datapath.
    hth_cmd_t    cmd;
    hth_status_t st;

    hth_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    // The datapath owns the height memory, the divider and the output register.
    hth_dp #(
        .GRID_CELLS (GRID_CELLS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .result_out (result_out),
        .cfg        (cfg),
        .cmd        (cmd),
        .st         (st)
    );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for heightfield_triangle_height: grid writes, height
// queries and cell spacing changes, checked against a local triangle predictor.
// Depends on hth_pkg, the channel interfaces in src/hth_if.sv and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import hth_pkg::*;

    localparam int GRID_CELLS = 20;
    localparam int GRID_SIDE  = GRID_CELLS + 1;
    localparam int RANDOM_ITEMS = 750;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic              op;
        logic [4:0]        x_index;
        logic [4:0]        z_index;
        logic signed [15:0] height_value;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_z;
    } item_t;

    typedef struct packed {
        logic signed [15:0] height;
        logic               out_of_range;
    } height_result_t;

    // One row of the directed part. When has_known is set, the expected result
    // is typed in the row and is also cross-checked against the predictor.
    typedef struct packed {
        item_t          item;
        logic           has_known;
        height_result_t known;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hth_in_if  item_in ();
    hth_out_if result_out ();
    hth_cfg_if cfg ();

    heightfield_triangle_height #(.GRID_CELLS(GRID_CELLS)) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .result_out (result_out),
        .cfg        (cfg)
    );

    always #1 clk = ~clk;

    // Predictor state: a private copy of the grid and of the spacing register.
    logic signed [15:0] grid_model [GRID_SIDE*GRID_SIDE];
    logic [14:0]        spacing_model;
    height_result_t     pending_heights [$];
    int                 failures = 0;
    int                 results_seen = 0;
    int                 queries_sent = 0;
    int                 off_grid_seen = 0;
    bit                 stimulus_done = 1'b0;

    // Floor division for a positive divisor.
    function automatic longint floor_div(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) < 0)
            q = q - 1;
        return q;
    endfunction

    // Applies one item to the predictor state and returns its result.
    function automatic height_result_t predict_height(item_t it);
        height_result_t r;
        longint s, u, w, i, j, fx, fz, n, q;
        longint h00, h10, h01, h11;
        r = '0;
        if (it.op == OP_WRITE)
        begin
            if (it.x_index <= GRID_CELLS && it.z_index <= GRID_CELLS)
                grid_model[it.x_index*GRID_SIDE + it.z_index] = it.height_value;
            return r;
        end
        s = longint'(spacing_model);
        if (s == 0)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        u = longint'(it.pos_x) + (GRID_CELLS/2) * s;
        w = (GRID_CELLS/2) * s - longint'(it.pos_z);
        if (u < 0 || w < 0 || u / s >= GRID_CELLS || w / s >= GRID_CELLS)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        i = u / s;
        j = w / s;
        fx = u - i*s;
        fz = w - j*s;
        h00 = grid_model[i*GRID_SIDE + j];
        h10 = grid_model[(i+1)*GRID_SIDE + j];
        h01 = grid_model[i*GRID_SIDE + j + 1];
        h11 = grid_model[(i+1)*GRID_SIDE + j + 1];
        // Upper-left triangle below the diagonal, lower-right on and past it.
        if (fx + fz < s)
            n = h00*s + (h10 - h00)*fx + (h01 - h00)*fz;
        else
            n = h11*s + (h01 - h11)*(s - fx) + (h10 - h11)*(s - fz);
        q = floor_div(2*n + s, 2*s);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        r.height = 16'(q);
        return r;
    endfunction

    // Drives one item through the handshake after a random gap, then records
    // its predicted result. When a typed-in result is given it is compared
    // with the predictor so that the predictor itself is checked.
    task automatic send_item(item_t it, bit has_known, height_result_t known);
        int gap;
        height_result_t r;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            item_in.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_in.valid        <= 1'b1;
        item_in.op           <= it.op;
        item_in.x_index      <= it.x_index;
        item_in.z_index      <= it.z_index;
        item_in.height_value <= it.height_value;
        item_in.pos_x        <= it.pos_x;
        item_in.pos_z        <= it.pos_z;
        do @(posedge clk); while (!item_in.ready);
        r = predict_height(it);
        if (has_known && r != known)
        begin
            $error("directed row: typed height %0d/%0b, predicted %0d/%0b",
                   known.height, known.out_of_range, r.height, r.out_of_range);
            failures++;
        end
        pending_heights.push_back(r);
        if (it.op == OP_QUERY)
            queries_sent++;
        @(negedge clk);
    endtask

    // Waits until every expected result has arrived, then lets the longest
    // query finish inside the block before anything else happens.
    task automatic wait_drained();
        item_in.valid <= 1'b0;
        while (pending_heights.size() != 0) @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic write_spacing(logic [14:0] value);
        cfg.valid        <= 1'b1;
        cfg.cell_spacing <= value;
        do @(posedge clk); while (!cfg.ready);
        spacing_model = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic item_t make_write(int xi, int zi, int hv);
        item_t it;
        it = '0;
        it.op = OP_WRITE;
        it.x_index = 5'(xi);
        it.z_index = 5'(zi);
        it.height_value = 16'(hv);
        it.pos_x = 16'($urandom);
        it.pos_z = 16'($urandom);
        return it;
    endfunction

    function automatic item_t make_query(int px, int pz);
        item_t it;
        it = '0;
        it.op = OP_QUERY;
        it.x_index = 5'($urandom);
        it.z_index = 5'($urandom);
        it.height_value = 16'($urandom);
        it.pos_x = 16'(px);
        it.pos_z = 16'(pz);
        return it;
    endfunction

    function automatic directed_row_t row(item_t it, bit has_known, int h, bit oor);
        directed_row_t d;
        d.item = it;
        d.has_known = has_known;
        d.known.height = 16'(h);
        d.known.out_of_range = oor;
        return d;
    endfunction

    // A random query point, mostly inside the grid at the current spacing.
    function automatic item_t random_query();
        longint span, px, pz;
        span = longint'(spacing_model) * (GRID_CELLS/2);
        if ($urandom_range(0, 9) < 8 && span > 0 && span < 32768)
        begin
            px = longint'($urandom_range(0, 2*span)) - span;
            pz = longint'($urandom_range(0, 2*span)) - span;
            if (px > 32767) px = 32767;
            if (pz > 32767) pz = 32767;
            return make_query(int'(px), int'(pz));
        end
        return make_query(int'($urandom_range(0, 65535)) - 32768,
                          int'($urandom_range(0, 65535)) - 32768);
    endfunction

    function automatic item_t random_write();
        int xi, zi;
        xi = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 20);
        zi = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 20);
        if ($urandom_range(0, 7) == 0)
            return make_write(xi, zi, $urandom_range(0, 1) ? 32767 : -32768);
        return make_write(xi, zi, int'($urandom_range(0, 65535)) - 32768);
    endfunction

    // Result side: random stall per item, compare each result with the
    // oldest expectation.
    initial
    begin
        int stall;
        height_result_t want;
        result_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                result_out.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_out.ready <= 1'b1;
            do @(posedge clk); while (!result_out.valid);
            if (pending_heights.size() == 0)
            begin
                $error("result item arrived with no expectation waiting");
                failures++;
            end
            else
            begin
                want = pending_heights.pop_front();
                if (result_out.height !== want.height)
                begin
                    $error("height: expected %0d, actual %0d", want.height,
                           result_out.height);
                    failures++;
                end
                if (result_out.out_of_range !== want.out_of_range)
                begin
                    $error("out_of_range: expected %0b, actual %0b",
                           want.out_of_range, result_out.out_of_range);
                    failures++;
                end
                if (want.out_of_range)
                    off_grid_seen++;
            end
            results_seen++;
            @(negedge clk);
        end
    end

    // Stimulus: directed table, a zero-spacing phase, then random phases at several spacings.
    initial
    begin
        directed_row_t directed [$];
        logic [14:0] spacings [6];
        height_result_t none;
        none = '0;
        item_in.valid = 1'b0;
        item_in.op = OP_WRITE;
        item_in.x_index = '0;
        item_in.z_index = '0;
        item_in.height_value = '0;
        item_in.pos_x = '0;
        item_in.pos_z = '0;
        cfg.valid = 1'b0;
        cfg.cell_spacing = '0;
        spacing_model = SPACING_RESET;
        foreach (grid_model[k]) grid_model[k] = HEIGHT_RESET;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // After reset every vertex is 1.0, so any point on the grid reads 1.0.
        directed.push_back(row(make_query(0, 0), 1, 256, 0));
        directed.push_back(row(make_query(-12800, 12800), 1, 256, 0));
        // Points just left of or above the grid, and past its far edges.
        directed.push_back(row(make_query(-12801, 0), 1, 0, 1));
        directed.push_back(row(make_query(0, 12801), 1, 0, 1));
        directed.push_back(row(make_query(12800, 0), 1, 0, 1));
        directed.push_back(row(make_query(0, -12800), 1, 0, 1));
        directed.push_back(row(make_query(-32768, -32768), 1, 0, 1));
        directed.push_back(row(make_query(32767, 32767), 1, 0, 1));
        // Writes return zero; indexes above the grid change nothing.
        directed.push_back(row(make_write(0, 0, 32767), 1, 0, 0));
        directed.push_back(row(make_write(1, 0, -32768), 1, 0, 0));
        directed.push_back(row(make_write(0, 1, -32768), 1, 0, 0));
        directed.push_back(row(make_write(20, 20, -32768), 1, 0, 0));
        directed.push_back(row(make_write(31, 0, 1234), 1, 0, 0));
        directed.push_back(row(make_write(0, 31, 1234), 1, 0, 0));
        directed.push_back(row(make_write(21, 21, 1234), 1, 0, 0));
        // A corner vertex, points near the first cell's diagonal, and two points deeper in the grid.
        directed.push_back(row(make_query(-12800, 12800), 1, 32767, 0));
        directed.push_back(row(make_query(-12160, 12160), 0, 0, 0));
        directed.push_back(row(make_query(-12161, 12160), 0, 0, 0));
        directed.push_back(row(make_query(-12159, 12160), 0, 0, 0));
        directed.push_back(row(make_query(-11521, 11521), 0, 0, 0));
        directed.push_back(row(make_query(12799, -12799), 0, 0, 0));
        directed.push_back(row(make_query(-1, 1), 0, 0, 0));

        foreach (directed[k])
            send_item(directed[k].item, directed[k].has_known, directed[k].known);

        // The sender holds off here until every result is back.
        wait_drained();

        // Zero spacing makes every query off the grid.
        write_spacing(15'd0);
        send_item(make_query(0, 0), 1, row(make_query(0, 0), 1, 0, 1).known);
        send_item(make_write(3, 3, 77), 1, none);
        send_item(make_query(-32768, 32767), 1, row(make_query(0, 0), 1, 0, 1).known);
        wait_drained();

        spacings[0] = 15'd1;
        spacings[1] = 15'd32767;
        spacings[2] = 15'd1280;
        spacings[3] = 15'(($urandom_range(0, 2000)) + 1);
        spacings[4] = 15'd3276;
        spacings[5] = 15'(($urandom_range(0, 32766)) + 1);
        foreach (spacings[p])
        begin
            write_spacing(spacings[p]);
            for (int k = 0; k < RANDOM_ITEMS / 6; k++)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_item(random_write(), 0, none);
                else
                    send_item(random_query(), 0, none);
            end
            wait_drained();
        end
        stimulus_done = 1'b1;
    end

    // End of run: wait for the stimulus to drain, then report.
    initial
    begin
        wait (stimulus_done);
        $display("Covered %0d results, %0d queries and %0d off-grid points", results_seen,
                 queries_sent, off_grid_seen);
        $display("over spacings from the smallest to the largest, zero included.");
        if (failures == 0 && pending_heights.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Watchdog: sized for 775 items with random gaps on both sides.
    initial
    begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+src
src/hth_pkg.sv
src/hth_if.sv
src/hth_div.sv
src/hth_dp.sv
src/hth_ctrl.sv
src/heightfield_triangle_height.sv
test/testbench.sv
